// ===== rtl/hsg_pkg.sv =====
package hsg_pkg;

    // configuration port geometry
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_INTERVAL    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_VERTICAL_STEP = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DURATION      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DURATION      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_TRAVEL        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_COMBO_WINDOW      = 3'd5;

    // run elapsed time, saturating
    localparam int               ELAPSED_W   = 17;
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = 17'h1FFFF;

    typedef struct packed {
        logic [9:0]  frame_interval;
        logic [13:0] max_vertical_step;
        logic [15:0] min_duration;
        logic [15:0] max_duration;
        logic [13:0] min_travel;
        logic [15:0] combo_window;
    } cfg_t;

    // swipe flags from the four run lanes
    typedef struct packed {
        logic left_lr;
        logic left_rl;
        logic right_lr;
        logic right_rl;
    } swipe_t;

    typedef enum logic [2:0] {
        GEST_NONE          = 3'd0,
        GEST_LEFT_LR       = 3'd1,
        GEST_RIGHT_RL      = 3'd2,
        GEST_BOTH_DOOR     = 3'd3,
        GEST_LEFT_RL_DOOR  = 3'd4,
        GEST_RIGHT_LR_DOOR = 3'd5,
        GEST_LEFT_RL       = 3'd6,
        GEST_RIGHT_LR      = 3'd7
    } gesture_t;

endpackage

// ===== rtl/hand_swipe_gesture_detector_core.sv =====
// Hand swipe detector: takes one frame of left and right hand positions per clock cycle
// while the output side is ready, and returns one gesture code per frame. Four
// run lanes (each hand, each direction) update their run state in the cycle that takes
// the frame; once the output register is free, the merging stage checks the runs,
// stamps the per-hand swipe times and loads the output register. A frame passes through
// the lane state register and then the output register.
// Configuration registers must be written only while no frame is in flight.
module hand_swipe_gesture_detector_core
    import hsg_pkg::*;
#(
    parameter int COORD_BITS = 14,
    parameter int TIME_BITS  = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [COORD_BITS-1:0] s_left_x,
    input  logic signed [COORD_BITS-1:0] s_left_y,
    input  logic signed [COORD_BITS-1:0] s_right_x,
    input  logic signed [COORD_BITS-1:0] s_right_y,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [2:0]                   m_gesture,
    input  logic                         cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_wdata
);

    cfg_t     cfg_reg;
    logic     check_valid_reg;
    logic     out_valid_reg;
    gesture_t gesture_reg;

    logic     accept;
    logic     advance;
    logic     out_free;
    swipe_t   swipe;
    gesture_t gesture;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.frame_interval    <= 10'd33;
            cfg_reg.max_vertical_step <= 14'd100;
            cfg_reg.min_duration      <= 16'd200;
            cfg_reg.max_duration      <= 16'd1000;
            cfg_reg.min_travel        <= 14'd300;
            cfg_reg.combo_window      <= 16'd500;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_FRAME_INTERVAL:    cfg_reg.frame_interval    <= cfg_wdata[9:0];
                CFG_MAX_VERTICAL_STEP: cfg_reg.max_vertical_step <= cfg_wdata[13:0];
                CFG_MIN_DURATION:      cfg_reg.min_duration      <= cfg_wdata;
                CFG_MAX_DURATION:      cfg_reg.max_duration      <= cfg_wdata;
                CFG_MIN_TRAVEL:        cfg_reg.min_travel        <= cfg_wdata[13:0];
                CFG_COMBO_WINDOW:      cfg_reg.combo_window      <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // handshake: lane state may only change once the checked transaction moves on
    assign out_free = !out_valid_reg || m_ready;
    assign advance  = check_valid_reg && out_free;
    assign s_ready  = !check_valid_reg || out_free;
    assign accept   = s_valid && s_ready;

    // run lanes
    hsg_run_lane #(.COORD_BITS(COORD_BITS), .RISING(1'b1)) u_lane_left_lr (
        .aclk(aclk), .aresetn(aresetn), .accept(accept),
        .x(s_left_x), .y(s_left_y), .cfg(cfg_reg), .swipe(swipe.left_lr)
    );
    hsg_run_lane #(.COORD_BITS(COORD_BITS), .RISING(1'b0)) u_lane_left_rl (
        .aclk(aclk), .aresetn(aresetn), .accept(accept),
        .x(s_left_x), .y(s_left_y), .cfg(cfg_reg), .swipe(swipe.left_rl)
    );
    hsg_run_lane #(.COORD_BITS(COORD_BITS), .RISING(1'b1)) u_lane_right_lr (
        .aclk(aclk), .aresetn(aresetn), .accept(accept),
        .x(s_right_x), .y(s_right_y), .cfg(cfg_reg), .swipe(swipe.right_lr)
    );
    hsg_run_lane #(.COORD_BITS(COORD_BITS), .RISING(1'b0)) u_lane_right_rl (
        .aclk(aclk), .aresetn(aresetn), .accept(accept),
        .x(s_right_x), .y(s_right_y), .cfg(cfg_reg), .swipe(swipe.right_rl)
    );

    // merging stage
    hsg_merge #(.TIME_BITS(TIME_BITS)) u_merge (
        .aclk(aclk), .aresetn(aresetn), .tick(accept), .advance(advance),
        .cfg(cfg_reg), .swipe(swipe), .gesture(gesture)
    );

    // pipeline control and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            check_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (accept) begin
                check_valid_reg <= 1'b1;
            end else if (advance) begin
                check_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            gesture_reg <= gesture;
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_gesture = gesture_reg;

`ifndef SYNTHESIS
    // a left L-to-R swipe always wins the priority
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && swipe.left_lr) |=> (m_gesture == GEST_LEFT_LR))
        else $error("left L-to-R swipe not reported");

    // an accepted transaction always reaches the check stage
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> check_valid_reg)
        else $error("accepted transaction lost before check stage");

    // a waiting checked transaction keeps the lanes frozen
    assert property (@(posedge aclk) disable iff (!aresetn)
        (check_valid_reg && !out_free) |=> check_valid_reg && $stable(swipe))
        else $error("lane state changed under a held transaction");
`endif

endmodule

// ===== rtl/hsg_run_lane.sv =====
module hsg_run_lane
    import hsg_pkg::*;
#(
    parameter int   COORD_BITS = 14,
    parameter logic RISING     = 1'b1
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         accept,
    input  logic signed [COORD_BITS-1:0] x,
    input  logic signed [COORD_BITS-1:0] y,
    input  cfg_t                         cfg,
    output logic                         swipe
);

    localparam int DW = COORD_BITS + 1;
    localparam int CW = DW + 14;

    logic                         valid_reg;
    logic signed [COORD_BITS-1:0] start_x_reg;
    logic signed [COORD_BITS-1:0] last_x_reg;
    logic signed [COORD_BITS-1:0] last_y_reg;
    logic [ELAPSED_W-1:0]         elapsed_reg;

    logic                         against;
    logic signed [DW-1:0]         dy;
    logic [DW-1:0]                dy_abs;
    logic                         restart;
    logic [ELAPSED_W:0]           elapsed_sum;
    logic [ELAPSED_W-1:0]         elapsed_next;
    logic signed [DW-1:0]         travel;
    logic [DW-1:0]                travel_abs;

    // restart test against the last point of the run
    always_comb begin
        if (RISING) begin
            against = x < last_x_reg;
        end else begin
            against = x > last_x_reg;
        end
        dy      = DW'(y) - DW'(last_y_reg);
        dy_abs  = dy[DW-1] ? DW'(-dy) : DW'(dy);
        restart = !valid_reg || against ||
                  (CW'(dy_abs) > CW'(cfg.max_vertical_step));
    end

    // elapsed time, saturating
    always_comb begin
        elapsed_sum = {1'b0, elapsed_reg} + (ELAPSED_W + 1)'(cfg.frame_interval);
        if (restart) begin
            elapsed_next = '0;
        end else if (elapsed_sum > (ELAPSED_W + 1)'(ELAPSED_MAX)) begin
            elapsed_next = ELAPSED_MAX;
        end else begin
            elapsed_next = elapsed_sum[ELAPSED_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (accept) begin
            valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            if (restart) begin
                start_x_reg <= x;
            end
            elapsed_reg <= elapsed_next;
            last_x_reg  <= x;
            last_y_reg  <= y;
        end
    end

    // swipe check on the stored run
    always_comb begin
        travel     = DW'(last_x_reg) - DW'(start_x_reg);
        travel_abs = travel[DW-1] ? DW'(-travel) : DW'(travel);
        swipe      = valid_reg &&
                     (elapsed_reg > ELAPSED_W'(cfg.min_duration)) &&
                     (elapsed_reg < ELAPSED_W'(cfg.max_duration)) &&
                     (CW'(travel_abs) > CW'(cfg.min_travel));
    end

endmodule

// ===== rtl/hsg_merge.sv =====
module hsg_merge
    import hsg_pkg::*;
#(
    parameter int TIME_BITS = 32
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     tick,
    input  logic     advance,
    input  cfg_t     cfg,
    input  swipe_t   swipe,
    output gesture_t gesture
);

    logic [TIME_BITS-1:0] now_time_reg;
    logic [TIME_BITS-1:0] left_time_reg;
    logic [TIME_BITS-1:0] right_time_reg;

    logic [TIME_BITS-1:0] left_time_next;
    logic [TIME_BITS-1:0] right_time_next;
    logic [TIME_BITS-1:0] since_left;
    logic [TIME_BITS-1:0] since_right;
    logic [TIME_BITS-1:0] window;
    logic                 priority_hit;
    logic                 lnow;
    logic                 rnow;

    // stamps of the opposite-direction swipes
    always_comb begin
        priority_hit    = swipe.left_lr || swipe.right_rl;
        left_time_next  = swipe.left_rl  ? now_time_reg : left_time_reg;
        right_time_next = swipe.right_lr ? now_time_reg : right_time_reg;
        since_left      = now_time_reg - left_time_next;
        since_right     = now_time_reg - right_time_next;
        window          = TIME_BITS'(cfg.combo_window);
        lnow            = left_time_next == now_time_reg;
        rnow            = right_time_next == now_time_reg;
    end

    // gesture priority
    always_comb begin
        if (swipe.left_lr) begin
            gesture = GEST_LEFT_LR;
        end else if (swipe.right_rl) begin
            gesture = GEST_RIGHT_RL;
        end else if (lnow && rnow) begin
            gesture = GEST_BOTH_DOOR;
        end else if (lnow && (since_right < window)) begin
            gesture = GEST_LEFT_RL_DOOR;
        end else if (rnow && (since_left < window)) begin
            gesture = GEST_RIGHT_LR_DOOR;
        end else if (lnow) begin
            gesture = GEST_LEFT_RL;
        end else if (rnow) begin
            gesture = GEST_RIGHT_LR;
        end else begin
            gesture = GEST_NONE;
        end
    end

    // frame clock and swipe stamps
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            now_time_reg   <= '0;
            left_time_reg  <= '0;
            right_time_reg <= '0;
        end else begin
            if (tick) begin
                now_time_reg <= now_time_reg + TIME_BITS'(cfg.frame_interval);
            end
            if (advance && !priority_hit) begin
                left_time_reg  <= left_time_next;
                right_time_reg <= right_time_next;
            end
        end
    end

endmodule
